// File: rtl/core/rau_pkg.sv
// Shared types, codes and constants for the rational arithmetic unit.
package rau_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int WIDE_WIDTH  = 2 * VALUE_WIDTH + 2;
   localparam int WIDE_CNT_WIDTH = $clog2(WIDE_WIDTH + 1);
   localparam int HALF_WIDTH  = 32;

   typedef logic [WIDE_WIDTH-1:0] wide_type;

   localparam logic [2:0] KIND_ADD = 3'd0;
   localparam logic [2:0] KIND_SUB = 3'd1;
   localparam logic [2:0] KIND_MUL = 3'd2;
   localparam logic [2:0] KIND_DIV = 3'd3;
   localparam logic [2:0] KIND_CMP = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DIV0 = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   localparam logic [1:0] ORDER_LESS    = 2'd0;
   localparam logic [1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [1:0] ORDER_GREATER = 2'd2;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_GCD,
      ALU_DIV,
      ALU_MUL
   } alu_op_type;

   // Request to the shared unit.
   typedef struct packed {
      logic       start;
      alu_op_type op;
      wide_type   a;
      wide_type   b;
   } alu_req_type;

   // Response from the shared unit.
   typedef struct packed {
      logic     done;
      wide_type result;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_N1G, ST_N1A, ST_N1B,
      ST_N2G, ST_N2A, ST_N2B,
      ST_SEL,
      ST_AG, ST_AM1, ST_AM2, ST_AQ, ST_AM3, ST_AM4, ST_ASUM,
      ST_MM1, ST_MM2,
      ST_CM1, ST_CM2, ST_CMP,
      ST_FG, ST_FA, ST_FB, ST_FCHK,
      ST_OUT
   } state_type;

endpackage

// File: rtl/core/rau_alu.sv
// Shared multicycle unit: binary gcd, restoring divide and shift-add multiply.
module rau_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::alu_req_type req,
   output rau_pkg::alu_rsp_type rsp
);

   localparam int W = rau_pkg::WIDE_WIDTH;

   typedef enum logic [2:0] {
      A_IDLE, A_GCD_STRIP, A_GCD_LOOP, A_GCD_FIX, A_DIV, A_MUL, A_DONE
   } astate_type;

   astate_type state_ff, state_in;
   rau_pkg::wide_type x_ff, x_in, y_ff, y_in, r_ff, r_in;
   rau_pkg::alu_op_type op_ff, op_in;
   logic [rau_pkg::WIDE_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   rau_pkg::wide_type diff, rem_sh;

   // Sequence the selected operation.
   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      r_in = r_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      diff = '0;
      rem_sh = '0;
      unique case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               op_in = req.op;
               x_in = req.a;
               y_in = req.b;
               r_in = '0;
               cnt_in = '0;
               unique case (req.op)
                  rau_pkg::ALU_GCD: begin
                     if (req.a == '0) begin
                        r_in = req.b;
                        state_in = A_DONE;
                     end else if (req.b == '0) begin
                        r_in = req.a;
                        state_in = A_DONE;
                     end else begin
                        state_in = A_GCD_STRIP;
                     end
                  end
                  rau_pkg::ALU_DIV: state_in = A_DIV;
                  default: state_in = A_MUL;
               endcase
            end
         end
         // Remove common factors of two, counting them.
         A_GCD_STRIP: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = A_GCD_LOOP;
            end
         end
         // One step: drop a factor of two or subtract the smaller.
         A_GCD_LOOP: begin
            if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff == y_ff) begin
               state_in = A_GCD_FIX;
            end else if (x_ff > y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         A_GCD_FIX: begin
            r_in = x_ff << cnt_ff;
            state_in = A_DONE;
         end
         // Restoring divide: x is dividend shifting into quotient, y divisor.
         A_DIV: begin
            rem_sh = {r_ff[W-2:0], x_ff[W-1]};
            diff = rem_sh - y_ff;
            if (rem_sh >= y_ff) begin
               r_in = diff;
               x_in = {x_ff[W-2:0], 1'b1};
            end else begin
               r_in = rem_sh;
               x_in = {x_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rau_pkg::WIDE_CNT_WIDTH'(W - 1)) begin
               state_in = A_DONE;
            end
         end
         // Shift-add multiply over the low operand bits.
         A_MUL: begin
            if (y_ff[0]) begin
               r_in = r_ff + x_ff;
            end
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rau_pkg::WIDE_CNT_WIDTH'(rau_pkg::HALF_WIDTH - 1)) begin
               state_in = A_DONE;
            end
         end
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
      op_ff <= op_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = (state_ff == A_DONE);
   assign rsp.result = (op_ff == rau_pkg::ALU_DIV) ? x_ff : r_ff;

endmodule

// File: rtl/core/rau_ctrl.sv
// Sequencer that steps one fraction operation through the shared unit.
module rau_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              kind,
   input  logic signed [31:0]      left_num,
   input  logic signed [31:0]      left_den,
   input  logic signed [31:0]      right_num,
   input  logic signed [31:0]      right_den,
   output rau_pkg::alu_req_type    alu_req,
   input  rau_pkg::alu_rsp_type    alu_rsp,
   output logic                    busy,
   output logic                    done,
   output logic [66:0]             result
);

   localparam int W = rau_pkg::WIDE_WIDTH;
   localparam int V = rau_pkg::VALUE_WIDTH;

   rau_pkg::state_type state_ff, state_in;
   rau_pkg::wide_type an_ff, an_in, ad_ff, ad_in, cn_ff, cn_in, cd_ff, cd_in;
   rau_pkg::wide_type t1_ff, t1_in, t2_ff, t2_in, g_ff, g_in;
   logic an_neg_ff, an_neg_in, cn_neg_ff, cn_neg_in, sn_ff, sn_in;
   logic [2:0] kind_ff, kind_in;
   logic [1:0] status_ff, status_in, order_ff, order_in;
   logic signed [31:0] rn_ff, rn_in;
   logic [30:0] rd_ff, rd_in;
   logic [V-1:0] lim;
   rau_pkg::wide_type lim_w, l_cmp, r_cmp;
   logic l_neg, r_neg;

   assign lim = {1'b1, {(V - 1){1'b0}}};
   assign lim_w = W'(lim);

   // Zero-extended magnitude of a VALUE_WIDTH operand.
   function automatic rau_pkg::wide_type mag(input logic [31:0] v);
      logic [V-1:0] t;
      t = v[V-1:0];
      if (t[V-1]) begin
         t = -t;
      end
      return W'(t);
   endfunction

   always_comb begin
      state_in = state_ff;
      an_in = an_ff; ad_in = ad_ff; cn_in = cn_ff; cd_in = cd_ff;
      t1_in = t1_ff; t2_in = t2_ff; g_in = g_ff;
      an_neg_in = an_neg_ff; cn_neg_in = cn_neg_ff; sn_in = sn_ff;
      kind_in = kind_ff; status_in = status_ff; order_in = order_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      alu_req = '0;
      l_cmp = '0; r_cmp = '0; l_neg = 1'b0; r_neg = 1'b0;
      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (start) begin
               kind_in = kind;
               status_in = rau_pkg::STATUS_OK;
               order_in = rau_pkg::ORDER_LESS;
               rn_in = '0;
               rd_in = 31'd1;
               an_in = mag(left_num);
               ad_in = mag(left_den);
               cn_in = mag(right_num);
               cd_in = mag(right_den);
               an_neg_in = left_num[V-1] ^ left_den[V-1];
               cn_neg_in = right_num[V-1] ^ right_den[V-1];
               if (left_den[V-1:0] == '0 || right_den[V-1:0] == '0) begin
                  status_in = rau_pkg::STATUS_DIV0;
                  state_in = rau_pkg::ST_OUT;
               end else begin
                  state_in = rau_pkg::ST_N1G;
               end
            end
         end
         // Normalize left operand.
         rau_pkg::ST_N1G: begin
            alu_req = '{1'b1, rau_pkg::ALU_GCD, an_ff, ad_ff};
            if (alu_rsp.done) begin
               g_in = alu_rsp.result;
               state_in = rau_pkg::ST_N1A;
            end
         end
         rau_pkg::ST_N1A: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, an_ff, g_ff};
            if (alu_rsp.done) begin
               an_in = alu_rsp.result;
               state_in = rau_pkg::ST_N1B;
            end
         end
         rau_pkg::ST_N1B: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, ad_ff, g_ff};
            if (alu_rsp.done) begin
               ad_in = alu_rsp.result;
               if (an_ff == '0) begin
                  ad_in = W'(1);
                  an_neg_in = 1'b0;
               end
               state_in = rau_pkg::ST_N2G;
            end
         end
         // Normalize right operand.
         rau_pkg::ST_N2G: begin
            alu_req = '{1'b1, rau_pkg::ALU_GCD, cn_ff, cd_ff};
            if (alu_rsp.done) begin
               g_in = alu_rsp.result;
               state_in = rau_pkg::ST_N2A;
            end
         end
         rau_pkg::ST_N2A: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, cn_ff, g_ff};
            if (alu_rsp.done) begin
               cn_in = alu_rsp.result;
               state_in = rau_pkg::ST_N2B;
            end
         end
         rau_pkg::ST_N2B: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, cd_ff, g_ff};
            if (alu_rsp.done) begin
               cd_in = alu_rsp.result;
               if (cn_ff == '0) begin
                  cd_in = W'(1);
                  cn_neg_in = 1'b0;
               end
               state_in = rau_pkg::ST_SEL;
            end
         end
         // Dispatch on operation.
         rau_pkg::ST_SEL: begin
            case (kind_ff) inside
               rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
                  if (kind_ff == rau_pkg::KIND_SUB && cn_ff != '0) begin
                     cn_neg_in = !cn_neg_ff;
                  end
                  state_in = rau_pkg::ST_AG;
               end
               rau_pkg::KIND_MUL: begin
                  sn_in = an_neg_ff ^ cn_neg_ff;
                  state_in = rau_pkg::ST_MM1;
               end
               rau_pkg::KIND_DIV: begin
                  if (cn_ff == '0) begin
                     status_in = rau_pkg::STATUS_DIV0;
                     state_in = rau_pkg::ST_OUT;
                  end else begin
                     // Swap the right operand's numerator and denominator.
                     sn_in = an_neg_ff ^ cn_neg_ff;
                     cd_in = cn_ff;
                     cn_in = cd_ff;
                     state_in = rau_pkg::ST_MM1;
                  end
               end
               default: state_in = rau_pkg::ST_CM1;
            endcase
         end
         // Add: g = gcd(b, d); p = a*(d/g), q = c*(b/g), den = (b/g)*d.
         rau_pkg::ST_AG: begin
            alu_req = '{1'b1, rau_pkg::ALU_GCD, ad_ff, cd_ff};
            if (alu_rsp.done) begin
               g_in = alu_rsp.result;
               state_in = rau_pkg::ST_AM1;
            end
         end
         rau_pkg::ST_AM1: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, cd_ff, g_ff};
            if (alu_rsp.done) begin
               t1_in = alu_rsp.result;
               state_in = rau_pkg::ST_AM2;
            end
         end
         rau_pkg::ST_AM2: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, an_ff, t1_ff};
            if (alu_rsp.done) begin
               t1_in = alu_rsp.result;
               state_in = rau_pkg::ST_AQ;
            end
         end
         rau_pkg::ST_AQ: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, ad_ff, g_ff};
            if (alu_rsp.done) begin
               t2_in = alu_rsp.result;
               g_in = alu_rsp.result;
               state_in = rau_pkg::ST_AM3;
            end
         end
         rau_pkg::ST_AM3: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, cn_ff, t2_ff};
            if (alu_rsp.done) begin
               t2_in = alu_rsp.result;
               state_in = rau_pkg::ST_AM4;
            end
         end
         rau_pkg::ST_AM4: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, g_ff, cd_ff};
            if (alu_rsp.done) begin
               ad_in = alu_rsp.result;
               state_in = rau_pkg::ST_ASUM;
            end
         end
         // Signed-magnitude sum of the scaled numerators.
         rau_pkg::ST_ASUM: begin
            if (an_neg_ff == cn_neg_ff) begin
               an_in = t1_ff + t2_ff;
               sn_in = an_neg_ff;
            end else if (t1_ff >= t2_ff) begin
               an_in = t1_ff - t2_ff;
               sn_in = an_neg_ff;
            end else begin
               an_in = t2_ff - t1_ff;
               sn_in = cn_neg_ff;
            end
            state_in = rau_pkg::ST_FG;
         end
         // Multiply (divide uses swapped right operand).
         rau_pkg::ST_MM1: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, an_ff, cn_ff};
            if (alu_rsp.done) begin
               an_in = alu_rsp.result;
               state_in = rau_pkg::ST_MM2;
            end
         end
         rau_pkg::ST_MM2: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, ad_ff, cd_ff};
            if (alu_rsp.done) begin
               ad_in = alu_rsp.result;
               state_in = rau_pkg::ST_FG;
            end
         end
         // Compare: a*d against c*b with signs.
         rau_pkg::ST_CM1: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, an_ff, cd_ff};
            if (alu_rsp.done) begin
               t1_in = alu_rsp.result;
               state_in = rau_pkg::ST_CM2;
            end
         end
         rau_pkg::ST_CM2: begin
            alu_req = '{1'b1, rau_pkg::ALU_MUL, cn_ff, ad_ff};
            if (alu_rsp.done) begin
               t2_in = alu_rsp.result;
               state_in = rau_pkg::ST_CMP;
            end
         end
         rau_pkg::ST_CMP: begin
            l_neg = an_neg_ff && t1_ff != '0;
            r_neg = cn_neg_ff && t2_ff != '0;
            l_cmp = t1_ff;
            r_cmp = t2_ff;
            if (l_neg != r_neg) begin
               order_in = l_neg ? rau_pkg::ORDER_LESS : rau_pkg::ORDER_GREATER;
            end else if (l_cmp == r_cmp) begin
               order_in = rau_pkg::ORDER_EQUAL;
            end else if ((l_cmp < r_cmp) != l_neg) begin
               order_in = rau_pkg::ORDER_LESS;
            end else begin
               order_in = rau_pkg::ORDER_GREATER;
            end
            state_in = rau_pkg::ST_OUT;
         end
         // Reduce result: an/ad with sign sn.
         rau_pkg::ST_FG: begin
            alu_req = '{1'b1, rau_pkg::ALU_GCD, an_ff, ad_ff};
            if (alu_rsp.done) begin
               g_in = alu_rsp.result;
               state_in = rau_pkg::ST_FA;
            end
         end
         rau_pkg::ST_FA: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, an_ff, g_ff};
            if (alu_rsp.done) begin
               an_in = alu_rsp.result;
               state_in = rau_pkg::ST_FB;
            end
         end
         rau_pkg::ST_FB: begin
            alu_req = '{1'b1, rau_pkg::ALU_DIV, ad_ff, g_ff};
            if (alu_rsp.done) begin
               ad_in = alu_rsp.result;
               if (an_ff == '0) begin
                  ad_in = W'(1);
                  sn_in = 1'b0;
               end
               state_in = rau_pkg::ST_FCHK;
            end
         end
         rau_pkg::ST_FCHK: begin
            if (ad_ff > lim_w - W'(1) || an_ff > (sn_ff ? lim_w : lim_w - W'(1))) begin
               status_in = rau_pkg::STATUS_OVF;
            end else begin
               rn_in = 32'(sn_ff ? -an_ff : an_ff);
               rd_in = 31'(ad_ff);
            end
            state_in = rau_pkg::ST_OUT;
         end
         rau_pkg::ST_OUT: state_in = rau_pkg::ST_IDLE;
         default: state_in = rau_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      an_ff <= an_in; ad_ff <= ad_in; cn_ff <= cn_in; cd_ff <= cd_in;
      t1_ff <= t1_in; t2_ff <= t2_in; g_ff <= g_in;
      an_neg_ff <= an_neg_in; cn_neg_ff <= cn_neg_in; sn_ff <= sn_in;
      kind_ff <= kind_in; status_ff <= status_in; order_ff <= order_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
   end

   assign busy = (state_ff != rau_pkg::ST_IDLE);
   assign done = (state_ff == rau_pkg::ST_OUT);
   // Packed result: num, den, order, status from the low bits up.
   assign result = (status_ff == rau_pkg::STATUS_OK)
                 ? {status_ff, order_ff, rd_ff, rn_ff}
                 : {status_ff, rau_pkg::ORDER_LESS, 31'd1, 32'd0};

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: stream ports and output register.
// Each operation runs its gcd, divide and multiply jobs on the shared unit in turn,
// from compare (fewest) to add or subtract (most); a zero input denominator skips
// them and goes straight to the result.
// Throughput: one item at a time; req_tready is low from acceptance until
// the result beat has been taken from the output register.
// Reset: synchronous, active high; clears the sequencer and output valid.
module rational_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind[2:0], left_num[34:3], left_den[66:35], right_num[98:67], right_den[130:99]
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_num[31:0], result_den[62:32], order[64:63], status[66:65]
   output logic [71:0]  rsp_tdata
);

   rau_pkg::alu_req_type alu_req;
   rau_pkg::alu_rsp_type alu_rsp;
   logic busy, done, start;
   logic [66:0] result;
   logic [71:0] data_ff, data_in;
   logic valid_ff, valid_in;
   logic pend_ff, pend_in;

   assign req_tready = !busy && !pend_ff;
   assign start = req_tvalid && req_tready;

   rau_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .kind      (req_tdata[2:0]),
      .left_num  (req_tdata[34:3]),
      .left_den  (req_tdata[66:35]),
      .right_num (req_tdata[98:67]),
      .right_den (req_tdata[130:99]),
      .alu_req   (alu_req),
      .alu_rsp   (alu_rsp),
      .busy      (busy),
      .done      (done),
      .result    (result)
   );

   // Hold the result beat until taken; block new items while it waits.
   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      pend_in = pend_ff;
      if (start) begin
         pend_in = 1'b1;
      end
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
         pend_in = 1'b0;
      end
      if (done) begin
         valid_in = 1'b1;
         data_in = {5'd0, result};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff <= pend_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("accepted while busy");
   a_den_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[62:32] != '0) else $error("zero denominator");
   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      done |-> pend_ff) else $error("result without item");

endmodule

// File: dv/testbench.sv
// Testbench for the rational arithmetic unit: random and directed fraction beats.
`timescale 1ns / 100ps

// Expected results of fraction operations, oldest first.
class fraction_scoreboard;
   logic [71:0] pending[$];
   int errors = 0;

   // Binary-free Euclid gcd on magnitudes.
   static function automatic longint unsigned gcd_mag(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   static function automatic longint unsigned mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Reduce a magnitude pair, check range, pack result; returns status.
   static function automatic logic [1:0] reduce(bit neg, longint unsigned nm,
                                                longint unsigned dm,
                                                output logic [31:0] rn,
                                                output logic [30:0] rd);
      longint unsigned g, lim;
      lim = 64'd1 << 31;
      g = gcd_mag(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if (nm == 0) begin
         dm = 1;
         neg = 0;
      end
      rn = 0;
      rd = 1;
      if (dm > lim - 1 || nm > (neg ? lim : lim - 1)) return rau_pkg::STATUS_OVF;
      rn = neg ? 32'(-nm) : 32'(nm);
      rd = 31'(dm);
      return rau_pkg::STATUS_OK;
   endfunction

   static function automatic void lowest_terms(longint n, longint d,
                                               output longint on, output longint od);
      bit neg;
      longint unsigned nm, dm, g;
      neg = (n < 0) != (d < 0);
      nm = mag(n);
      dm = mag(d);
      g = gcd_mag(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if (nm == 0) begin
         dm = 1;
         neg = 0;
      end
      on = neg ? -longint'(nm) : longint'(nm);
      od = dm;
   endfunction

   // Note an accepted request beat and queue its expected result.
   function void note_request(logic [135:0] data);
      logic [2:0] kind;
      longint a, b, c, d, p, q, g, l, r;
      longint unsigned pm, qm, sm;
      bit sn;
      logic [31:0] rn;
      logic [30:0] rd;
      logic [1:0] ord, st;
      kind = data[2:0];
      a = longint'(signed'(data[34:3]));
      b = longint'(signed'(data[66:35]));
      c = longint'(signed'(data[98:67]));
      d = longint'(signed'(data[130:99]));
      rn = 0;
      rd = 1;
      ord = rau_pkg::ORDER_LESS;
      st = rau_pkg::STATUS_OK;
      if (b == 0 || d == 0) begin
         st = rau_pkg::STATUS_DIV0;
      end else begin
         lowest_terms(a, b, a, b);
         lowest_terms(c, d, c, d);
         if (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB) begin
            if (kind == rau_pkg::KIND_SUB) c = -c;
            g = gcd_mag(b, d);
            p = a * (d / g);
            q = c * (b / g);
            pm = mag(p);
            qm = mag(q);
            if ((p < 0) == (q < 0)) begin
               sm = pm + qm;
               sn = p < 0;
            end else if (pm >= qm) begin
               sm = pm - qm;
               sn = p < 0;
            end else begin
               sm = qm - pm;
               sn = q < 0;
            end
            st = reduce(sn, sm, (b / g) * d, rn, rd);
         end else if (kind == rau_pkg::KIND_MUL) begin
            st = reduce((a < 0) != (c < 0), mag(a) * mag(c), b * d, rn, rd);
         end else if (kind == rau_pkg::KIND_DIV) begin
            if (c == 0) st = rau_pkg::STATUS_DIV0;
            else st = reduce((a < 0) != (c < 0), mag(a) * d, b * mag(c), rn, rd);
         end else begin
            l = a * d;
            r = c * b;
            ord = l < r ? rau_pkg::ORDER_LESS :
                  (l == r ? rau_pkg::ORDER_EQUAL : rau_pkg::ORDER_GREATER);
         end
      end
      if (st != rau_pkg::STATUS_OK) begin
         rn = 0;
         rd = 1;
         ord = rau_pkg::ORDER_LESS;
      end
      pending.push_back({5'd0, st, ord, rd, rn});
   endfunction

   // Compare a result beat with the oldest expectation.
   function void check_result(logic [71:0] got);
      logic [71:0] want;
      if (pending.size() == 0) begin
         $display("%0t unexpected result beat %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got[31:0] !== want[31:0]) begin
         $display("%0t result_num expected %0d got %0d", $time,
                  $signed(want[31:0]), $signed(got[31:0]));
         errors++;
      end
      if (got[62:32] !== want[62:32]) begin
         $display("%0t result_den expected %0d got %0d", $time, want[62:32], got[62:32]);
         errors++;
      end
      if (got[64:63] !== want[64:63]) begin
         $display("%0t order expected %0d got %0d", $time, want[64:63], got[64:63]);
         errors++;
      end
      if (got[66:65] !== want[66:65]) begin
         $display("%0t status expected %0d got %0d", $time, want[66:65], got[66:65]);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;

   fraction_scoreboard board = new();
   int  send_idle = 0;
   int  recv_stall = 0;
   longint cycles = 0;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   rational_arithmetic_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Watchdog and result side: check beats, randomize ready.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rational_arithmetic_unit: mismatch");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // Draw an operand: mostly small, sometimes extreme or fully random.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'($urandom_range(65535)) << $urandom_range(16);
         4: return 0;
         default: return 32'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   // Send one request beat and hold until accepted; drop valid only while idling.
   task automatic send(logic [2:0] kind, logic [31:0] a, logic [31:0] b,
                       logic [31:0] c, logic [31:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, d, c, b, a, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(req_tdata);
   endtask

   initial begin
      logic [31:0] b, d;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: every kind, extremes, zero denominators, divide by zero.
      for (int k = 0; k < 8; k++) send(k[2:0], 32'd3, 32'hffff_fffa, 32'd5, 32'd10);
      send(rau_pkg::KIND_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
      send(rau_pkg::KIND_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
      send(rau_pkg::KIND_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      send(rau_pkg::KIND_MUL, 1, 32'h8000_0000, 1, 32'h7fff_ffff);
      send(rau_pkg::KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1);
      send(rau_pkg::KIND_DIV, 7, 3, 0, 5);
      send(rau_pkg::KIND_ADD, 7, 0, 1, 2);
      send(rau_pkg::KIND_CMP, 1, 2, 1, 0);
      send(rau_pkg::KIND_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send(rau_pkg::KIND_CMP, 2, 4, 32'hffff_ffff, 32'hffff_fffe);
      send(rau_pkg::KIND_SUB, 5, 7, 5, 7);
      send(rau_pkg::KIND_ADD, 1, 32'h7fff_fffe, 1, 32'h7fff_ffff);
      send(rau_pkg::KIND_MUL, 0, 32'hffff_ffff, 32'h1234_5678, 3);
      // Random phases with different idle patterns.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 86; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 86; end
            3: begin send_idle = 16; recv_stall = 16; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         for (int i = 0; i < 380; i++) begin
            b = pick_value();
            d = pick_value();
            if ($urandom_range(19) != 0 && b == 0) b = 1;
            if ($urandom_range(19) != 0 && d == 0) d = 32'hffff_ffff;
            send(3'($urandom_range(7)), pick_value(), b, pick_value(), d);
         end
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (board.errors == 0) $display("rational_arithmetic_unit: match");
      else $display("rational_arithmetic_unit: mismatch");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/rau_pkg.sv
rtl/core/rau_alu.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
dv/testbench.sv
